FILE: rtl/core/dtpq_pkg.sv
// Package for the drop-tail packet queue: sizes, event codes, register
// indexes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package dtpq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TAG_W       = 16;
    localparam int SIZE_W      = 16;
    localparam int BYTES_W     = 22;
    localparam int LIMIT_W     = 7;
    localparam int MEAN_W      = 16;
    localparam int PROD_W      = LIMIT_W + MEAN_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        EV_ACCEPT = 2'd0,
        EV_DROP   = 2'd1,
        EV_DEQ    = 2'd2,
        EV_EMPTY  = 2'd3
    } event_t;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT_PACKETS = 2'd0,
        REG_MEAN_SIZE     = 2'd1,
        REG_BYTE_MODE     = 2'd2,
        REG_DROP_FRONT    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic take_item;
        logic execute;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/dtpq_in_if.sv
// Input channel: valid/ready with enqueue/dequeue command payload.
// Depends on dtpq_pkg.
`timescale 1ns / 1ps

interface dtpq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [dtpq_pkg::TAG_W-1:0]    packet_tag;
    logic [dtpq_pkg::SIZE_W-1:0]   packet_size;

    modport source (output valid, output cmd, output packet_tag, output packet_size,
                    input ready);
    modport sink   (input valid, input cmd, input packet_tag, input packet_size,
                    output ready);
endinterface

FILE: rtl/core/dtpq_out_if.sv
// Output channel: valid/ready with event and occupancy payload.
// Depends on dtpq_pkg.
`timescale 1ns / 1ps

interface dtpq_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    event_kind;
    logic [dtpq_pkg::TAG_W-1:0]    out_tag;
    logic [dtpq_pkg::SIZE_W-1:0]   out_size;
    logic [dtpq_pkg::CNT_W-1:0]    held_packets;
    logic [dtpq_pkg::BYTES_W-1:0]  held_bytes;

    modport source (output valid, output event_kind, output out_tag, output out_size,
                    output held_packets, output held_bytes, input ready);
    modport sink   (input valid, input event_kind, input out_tag, input out_size,
                    input held_packets, input held_bytes, output ready);
endinterface

FILE: rtl/core/dtpq_ctrl.sv
// Controller FSM: takes one beat, then runs it once the output slot is free.
// Depends on dtpq_pkg.
`timescale 1ns / 1ps

module dtpq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dtpq_pkg::dp_status_t status,
    output dtpq_pkg::dp_cmd_t    cmd
);

    dtpq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtpq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtpq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dtpq_pkg::ST_EXEC;
                end
            end
            dtpq_pkg::ST_EXEC:
            begin
                if (status.out_free)
                begin
                    state_next = dtpq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.take_item = 1'b0;
        cmd.execute   = 1'b0;
        case (state_reg)
            dtpq_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_item = in_valid;
            end
            dtpq_pkg::ST_EXEC:
            begin
                cmd.execute = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/dtpq_datapath.sv
// Datapath: config registers, descriptor store, head/tail/counters,
// admission decision and the output register. Depends on dtpq_pkg.
`timescale 1ns / 1ps

module dtpq_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dtpq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dtpq_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_cmd,
    input  logic [dtpq_pkg::TAG_W-1:0]         in_tag,
    input  logic [dtpq_pkg::SIZE_W-1:0]        in_size,
    input  dtpq_pkg::dp_cmd_t                  cmd,
    output dtpq_pkg::dp_status_t               status,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [1:0]                         out_event,
    output logic [dtpq_pkg::TAG_W-1:0]         out_tag,
    output logic [dtpq_pkg::SIZE_W-1:0]        out_size,
    output logic [dtpq_pkg::CNT_W-1:0]         out_packets,
    output logic [dtpq_pkg::BYTES_W-1:0]       out_bytes
);

    localparam int DEPTH = dtpq_pkg::QUEUE_DEPTH;
    localparam int IW    = dtpq_pkg::IDX_W;
    localparam int CW    = dtpq_pkg::CNT_W;
    localparam int BW    = dtpq_pkg::BYTES_W;
    localparam int PW    = dtpq_pkg::PROD_W;

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // config
    logic [dtpq_pkg::LIMIT_W-1:0] limit_reg;
    logic [dtpq_pkg::MEAN_W-1:0]  mean_reg;
    logic                         byte_mode_reg;
    logic                         drop_front_reg;
    logic [PW-1:0]                byte_limit;

    // captured beat
    logic                         op_reg;
    logic [dtpq_pkg::TAG_W-1:0]   tag_reg;
    logic [dtpq_pkg::SIZE_W-1:0]  size_reg;

    // queue state
    logic [dtpq_pkg::TAG_W-1:0]   tag_mem  [DEPTH];
    logic [dtpq_pkg::SIZE_W-1:0]  size_mem [DEPTH];
    logic [dtpq_pkg::TAG_W-1:0]   head_tag_reg;
    logic [dtpq_pkg::SIZE_W-1:0]  head_size_reg;
    logic [IW-1:0]                head_reg, head_next;
    logic [IW-1:0]                tail_reg, tail_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [BW-1:0]                bytes_reg, bytes_next;

    // output register
    logic                         out_valid_reg;
    dtpq_pkg::event_t             event_reg, event_next;
    logic [dtpq_pkg::TAG_W-1:0]   otag_reg, otag_next;
    logic [dtpq_pkg::SIZE_W-1:0]  osize_reg, osize_next;

    logic          push;
    logic          pop;
    logic          over;
    logic          non_empty;
    logic [CW:0]   count_plus;
    logic [PW-1:0] bytes_plus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= dtpq_pkg::LIMIT_W'(50);
            mean_reg       <= dtpq_pkg::MEAN_W'(500);
            byte_mode_reg  <= 1'b0;
            drop_front_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (dtpq_pkg::cfg_reg_t'(cfg_index))
                dtpq_pkg::REG_LIMIT_PACKETS: limit_reg <= cfg_data[dtpq_pkg::LIMIT_W-1:0];
                dtpq_pkg::REG_MEAN_SIZE:     mean_reg <= cfg_data[dtpq_pkg::MEAN_W-1:0];
                dtpq_pkg::REG_BYTE_MODE:     byte_mode_reg <= cfg_data[0];
                dtpq_pkg::REG_DROP_FRONT:    drop_front_reg <= cfg_data[0];
                default:                     limit_reg <= limit_reg;
            endcase
        end
    end

    // byte limit from the config registers
    assign byte_limit = PW'(limit_reg) * PW'(mean_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            op_reg   <= in_cmd;
            tag_reg  <= in_tag;
            size_reg <= in_size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            tag_mem[tail_reg]  <= tag_reg;
            size_mem[tail_reg] <= size_reg;
        end
        head_tag_reg  <= tag_mem[head_reg];
        head_size_reg <= size_mem[head_reg];
    end

    assign non_empty  = (count_reg != '0);
    assign count_plus = {1'b0, count_reg} + (CW+1)'(1);
    assign bytes_plus = PW'(bytes_reg) + PW'(size_reg);

    always_comb
    begin
        if (byte_mode_reg)
        begin
            over = (bytes_plus >= byte_limit);
        end
        else
        begin
            over = (count_plus >= (CW+1)'(limit_reg));
        end
        if (count_reg >= FULL_CNT)
        begin
            over = 1'b1;
        end
    end

    always_comb
    begin
        push       = 1'b0;
        pop        = 1'b0;
        event_next = dtpq_pkg::EV_EMPTY;
        otag_next  = '0;
        osize_next = '0;
        if (op_reg == dtpq_pkg::CMD_ENQ)
        begin
            if (!over)
            begin
                push       = cmd.execute;
                event_next = dtpq_pkg::EV_ACCEPT;
            end
            else if (drop_front_reg && non_empty)
            begin
                push       = cmd.execute;
                pop        = cmd.execute;
                event_next = dtpq_pkg::EV_DROP;
                otag_next  = head_tag_reg;
                osize_next = head_size_reg;
            end
            else
            begin
                event_next = dtpq_pkg::EV_DROP;
                otag_next  = tag_reg;
                osize_next = size_reg;
            end
        end
        else if (non_empty)
        begin
            pop        = cmd.execute;
            event_next = dtpq_pkg::EV_DEQ;
            otag_next  = head_tag_reg;
            osize_next = head_size_reg;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        bytes_next = bytes_reg;
        if (pop)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
        end
        if (push)
        begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
        bytes_next = bytes_reg + (push ? BW'(size_reg) : '0) - (pop ? BW'(head_size_reg) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            bytes_reg <= bytes_next;
            if (cmd.execute)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            event_reg <= event_next;
            otag_reg  <= otag_next;
            osize_reg <= osize_next;
        end
    end

    // held counts track the queue registers, which only move on execute
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_event       = event_reg;
    assign out_tag         = otag_reg;
    assign out_size        = osize_reg;
    assign out_packets     = count_reg;
    assign out_bytes       = bytes_reg;

endmodule

FILE: rtl/core/drop_tail_packet_queue.sv
// Top level of the drop-tail packet queue: controller plus datapath.
// Depends on dtpq_pkg, dtpq_in_if, dtpq_out_if, dtpq_ctrl, dtpq_datapath.
//
// Usage:
//   in_ch carries one command per beat: cmd 0 enqueues (packet_tag,
//   packet_size), cmd 1 dequeues the head. out_ch returns one result beat
//   per command: event_kind, the dropped/dequeued descriptor, and the
//   packets and bytes held after the command.
//   Config is a plain write port (cfg_we, cfg_index, cfg_data); write only
//   while no command is outstanding.
//   A command is captured into the beat registers, then executes into the
//   output register once it is free. A new command is taken only after the
//   last one has executed; the descriptor store read of the head is
//   registered, so each command passes through capture and then execute.
//   The next command is accepted while a result still sits in the output
//   register; if the receiver stalls, that command waits in execute until
//   the output register frees, and in_ch.ready drops meanwhile.
//   Reset empties the queue and restores limit 50, mean size 500, packet
//   mode, drop-tail. The descriptor store is not cleared.
`timescale 1ns / 1ps

module drop_tail_packet_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    dtpq_in_if.sink                             in_ch,
    dtpq_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [dtpq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dtpq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dtpq_pkg::dp_cmd_t    cmd;
    dtpq_pkg::dp_status_t status;

    dtpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    dtpq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_cmd      (in_ch.cmd),
        .in_tag      (in_ch.packet_tag),
        .in_size     (in_ch.packet_size),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_event   (out_ch.event_kind),
        .out_tag     (out_ch.out_tag),
        .out_size    (out_ch.out_size),
        .out_packets (out_ch.held_packets),
        .out_bytes   (out_ch.held_bytes)
    );

endmodule

FILE: tb/tb_drop_tail_packet_queue.sv
// Self-checking testbench for drop_tail_packet_queue: directed and random
// enqueue/dequeue traffic, checked beat by beat against an in-bench queue predictor.
// Depends on dtpq_pkg, dtpq_in_if, dtpq_out_if and the RTL top level.
`timescale 1ns / 1ps

module tb_drop_tail_packet_queue;
    import dtpq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        event_t                    kind;
        logic [TAG_W-1:0]          tag;
        logic [SIZE_W-1:0]         size;
        logic [CNT_W-1:0]          packets;
        logic [BYTES_W-1:0]        bytes;
    } queue_event_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dtpq_in_if  in_ch ();
    dtpq_out_if out_ch ();

    drop_tail_packet_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [TAG_W-1:0]  model_tags[$];
    logic [SIZE_W-1:0] model_sizes[$];
    int unsigned       held_bytes_m;
    int unsigned       limit_m;
    int unsigned       mean_m;
    logic              byte_mode_m;
    logic              drop_front_m;

    queue_event_t pending_events[$];
    int           error_count;
    int unsigned  cycle_count;
    int           tx_idle_pct;
    int           rx_idle_pct;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : check_beat
        queue_event_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected result beat: event_kind %0d tag %0h",
                       out_ch.event_kind, out_ch.out_tag);
                error_count++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (out_ch.event_kind !== want.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", want.kind, out_ch.event_kind);
                    error_count++;
                end
                if (out_ch.out_tag !== want.tag)
                begin
                    $error("out_tag: expected %0h, got %0h", want.tag, out_ch.out_tag);
                    error_count++;
                end
                if (out_ch.out_size !== want.size)
                begin
                    $error("out_size: expected %0d, got %0d", want.size, out_ch.out_size);
                    error_count++;
                end
                if (out_ch.held_packets !== want.packets)
                begin
                    $error("held_packets: expected %0d, got %0d",
                           want.packets, out_ch.held_packets);
                    error_count++;
                end
                if (out_ch.held_bytes !== want.bytes)
                begin
                    $error("held_bytes: expected %0d, got %0d", want.bytes, out_ch.held_bytes);
                    error_count++;
                end
            end
        end
    end

    task automatic predict_queue_event(input op_t op, input logic [TAG_W-1:0] tag,
                                       input logic [SIZE_W-1:0] size);
        queue_event_t ev;
        logic         overflow;
        ev = '0;
        if (op == CMD_ENQ)
        begin
            if (byte_mode_m)
                overflow = (held_bytes_m + size) >= (limit_m * mean_m);
            else
                overflow = (model_tags.size() + 1) >= limit_m;
            if (model_tags.size() >= QUEUE_DEPTH)
                overflow = 1'b1;
            ev.kind = EV_DROP;
            if (!overflow || (drop_front_m && model_tags.size() != 0))
            begin
                if (overflow)
                begin
                    ev.tag = model_tags.pop_front();
                    ev.size = model_sizes.pop_front();
                    held_bytes_m -= ev.size;
                end
                else
                    ev.kind = EV_ACCEPT;
                model_tags.push_back(tag);
                model_sizes.push_back(size);
                held_bytes_m += size;
            end
            else
            begin
                ev.tag = tag;
                ev.size = size;
            end
        end
        else if (model_tags.size() != 0)
        begin
            ev.kind = EV_DEQ;
            ev.tag = model_tags.pop_front();
            ev.size = model_sizes.pop_front();
            held_bytes_m -= ev.size;
        end
        else
            ev.kind = EV_EMPTY;
        ev.packets = CNT_W'(model_tags.size());
        ev.bytes = BYTES_W'(held_bytes_m);
        pending_events.push_back(ev);
    endtask

    task automatic send_cmd(input op_t op, input logic [TAG_W-1:0] tag,
                            input logic [SIZE_W-1:0] size);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= op;
        in_ch.packet_tag  <= tag;
        in_ch.packet_size <= size;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_queue_event(op, tag, size);
    endtask

    task automatic dequeue_head();
        send_cmd(CMD_DEQ, TAG_W'($urandom), SIZE_W'($urandom));
    endtask

    task automatic drain_queue();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    // only called with the queue drained
    task automatic apply_config(input int unsigned lim, input int unsigned mean,
                                input logic bmode, input logic dfront);
        write_reg(REG_LIMIT_PACKETS, CFG_DATA_W'(lim));
        write_reg(REG_MEAN_SIZE, CFG_DATA_W'(mean));
        write_reg(REG_BYTE_MODE, CFG_DATA_W'(bmode));
        write_reg(REG_DROP_FRONT, CFG_DATA_W'(dfront));
        @(negedge clk);
        cfg_we <= 1'b0;
        limit_m      = lim & 7'h7F;
        mean_m       = mean & 16'hFFFF;
        byte_mode_m  = bmode;
        drop_front_m = dfront;
    endtask

    task automatic test_reset_defaults();
        dequeue_head();
        send_cmd(CMD_ENQ, 16'h0000, 16'h0000);
        send_cmd(CMD_ENQ, 16'hFFFF, 16'hFFFF);
        dequeue_head();
        dequeue_head();
        dequeue_head();
        drain_queue();
    endtask

    task automatic test_packet_limit();
        apply_config(2, 500, 1'b0, 1'b0);
        send_cmd(CMD_ENQ, 16'hA001, 16'd100);
        send_cmd(CMD_ENQ, 16'hA002, 16'd200);
        drain_queue();
        apply_config(2, 500, 1'b0, 1'b1);
        send_cmd(CMD_ENQ, 16'hA003, 16'd300);
        dequeue_head();
        drain_queue();
        // drop-front with an empty queue drops the arrival itself
        apply_config(1, 500, 1'b0, 1'b1);
        send_cmd(CMD_ENQ, 16'hA004, 16'd400);
        drain_queue();
    endtask

    task automatic test_byte_limit();
        apply_config(2, 100, 1'b1, 1'b0);
        send_cmd(CMD_ENQ, 16'hB001, 16'd150);
        send_cmd(CMD_ENQ, 16'hB002, 16'd50);
        send_cmd(CMD_ENQ, 16'hB003, 16'd49);
        drain_queue();
        apply_config(2, 100, 1'b1, 1'b1);
        send_cmd(CMD_ENQ, 16'hB004, 16'd1);
        dequeue_head();
        dequeue_head();
        drain_queue();
    endtask

    task automatic test_limit_zero();
        apply_config(0, 500, 1'b0, 1'b0);
        send_cmd(CMD_ENQ, 16'hC001, 16'd10);
        drain_queue();
        apply_config(0, 65535, 1'b1, 1'b0);
        send_cmd(CMD_ENQ, 16'hC002, 16'd0);
        drain_queue();
    endtask

    // limit above the store depth: only the full-store check bounds the queue
    task automatic test_full_store();
        apply_config(100, 500, 1'b0, 1'b0);
        repeat (QUEUE_DEPTH + 2) send_cmd(CMD_ENQ, TAG_W'($urandom), SIZE_W'($urandom));
        drain_queue();
        apply_config(100, 500, 1'b0, 1'b1);
        repeat (5) send_cmd(CMD_ENQ, TAG_W'($urandom), SIZE_W'($urandom));
        repeat (QUEUE_DEPTH + 2) dequeue_head();
        drain_queue();
    endtask

    task automatic test_random_traffic(input int phases, input int items_per_phase);
        int unsigned       lim;
        int unsigned       mean;
        int                enq_pct;
        logic [SIZE_W-1:0] size;
        for (int p = 0; p < phases; p++)
        begin
            case ($urandom_range(5))
                0: lim = 1;
                1: lim = 2;
                2: lim = QUEUE_DEPTH;
                3: lim = $urandom_range(65, 127);
                default: lim = $urandom_range(3, 63);
            endcase
            case ($urandom_range(3))
                0: mean = 1;
                1: mean = 65535;
                2: mean = $urandom_range(100, 3000);
                default: mean = $urandom_range(1, 65535);
            endcase
            if (p == 0)
                apply_config(QUEUE_DEPTH, 65535, 1'b1, 1'b0);
            else if (p == 1)
                apply_config(1, 1, 1'b1, 1'b1);
            else
                apply_config(lim, mean, 1'($urandom_range(1)), 1'($urandom_range(1)));
            for (int i = 0; i < items_per_phase; i++)
            begin
                enq_pct = ((i / 40) % 2 == 0) ? 80 : 30;
                case ($urandom_range(3))
                    0: size = SIZE_W'($urandom_range(0, 65535));
                    1: size = SIZE_W'($urandom_range(0, 1023));
                    2: size = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    default: size = SIZE_W'($urandom_range(0, 255));
                endcase
                if ($urandom_range(99) < enq_pct)
                    send_cmd(CMD_ENQ, TAG_W'($urandom), size);
                else
                    send_cmd(CMD_DEQ, TAG_W'($urandom), size);
            end
            drain_queue();
        end
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_LIMIT_PACKETS;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_ENQ;
        in_ch.packet_tag  = '0;
        in_ch.packet_size = '0;
        out_ch.ready      = 1'b0;
        error_count       = 0;
        cycle_count       = 0;
        held_bytes_m      = 0;
        limit_m           = 50;
        mean_m            = 500;
        byte_mode_m       = 1'b0;
        drop_front_m      = 1'b0;
        tx_idle_pct       = 19;
        rx_idle_pct       = 46;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_packet_limit();
        test_byte_limit();
        test_limit_zero();
        test_random_traffic(4, 150);

        tx_idle_pct = 46;
        rx_idle_pct = 19;
        test_full_store();
        test_random_traffic(4, 150);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(4, 150);

        drain_queue();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
